// ===== design/double_ended_queue_defines.svh =====
// Assertion macros shared by the double-ended queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("double_ended_queue: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("double_ended_queue: next-cycle check failed");

`endif

// ===== design/deq_pkg.sv =====
// Shared constants for the double-ended queue: widths, opcodes and status codes.
// Depends on nothing; used by the interfaces and the top level.
`default_nettype none

package deq_pkg;

    // Default ring depth.
    localparam int DefaultDepth = 64;

    // Payload widths.
    localparam int OpW   = 3;
    localparam int DataW = 32;
    localparam int StW   = 2;

    // Command opcodes.
    localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OpW-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OpW-1:0] OP_LIST       = 3'd4;

    // Result status codes.
    localparam logic [StW-1:0] ST_OK    = 2'd0;
    localparam logic [StW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StW-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== design/deq_ifs.sv =====
// Valid/ready channel interfaces for the double-ended queue command and result.
// Depends on deq_pkg for the payload widths.
`default_nettype none

// Command channel: opcode and value.
interface deq_cmd_if;
    logic                               valid;
    logic                               ready;
    logic        [deq_pkg::OpW-1:0]     opcode;
    logic signed [deq_pkg::DataW-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// Result channel: status, data and last marker.
interface deq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [deq_pkg::StW-1:0]     status;
    logic signed [deq_pkg::DataW-1:0]   data;
    logic                               last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values held as a ring in one memory of DEPTH
// entries with a front pointer and an element count. Push front, push back, pop front
// and pop back each take one command transaction and give one result transaction; with
// the result side ready, one command is accepted every cycle. A pop reads the memory at
// acceptance and its result reaches the output through a result stage and an output
// register. A list command gives one result per held element, since the single read
// port delivers one entry a cycle while the result stage has room; an empty list gives
// one status result. Commands are not accepted while a list is streaming. Unknown
// opcodes are consumed with no result. The memory needs no clearing after reset.
`default_nettype none
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DefaultDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_cmd_if.sink    i_cmd,
    deq_rsp_if.source  o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] FullCount = CW'(DEPTH);
    localparam logic [SW-1:0] DepthSum  = SW'(DEPTH);
    localparam logic [AW-1:0] LastAddr  = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } t_state;

    // Ring index of an offset from a base slot, wrapped modulo DEPTH.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= DepthSum) begin
            sum = sum - DepthSum;
        end
        return sum[AW-1:0];
    endfunction

    // Control state.
    t_state          r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_lidx,  n_lidx;

    // Ring storage and its registered read data.
    logic signed [deq_pkg::DataW-1:0] r_mem [DEPTH];
    logic signed [deq_pkg::DataW-1:0] r_rd_data;

    // Result stage, aligned with the memory read data.
    logic                      r_stg_vld;
    logic [deq_pkg::StW-1:0]   r_stg_status;
    logic                      r_stg_last;
    logic                      r_stg_mem;

    // Output register.
    logic                             r_out_vld;
    logic [deq_pkg::StW-1:0]          r_out_status;
    logic signed [deq_pkg::DataW-1:0] r_out_data;
    logic                             r_out_last;

    logic                    out_free, stg_move, stg_room, in_ready, in_fire;
    logic                    is_empty, is_full;
    logic                    wr_en, rd_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic                    ld_stg, ld_last, ld_mem;
    logic [deq_pkg::StW-1:0] ld_status;

    // Handshake bookkeeping across the two result registers.
    assign out_free = !r_out_vld || o_rsp.ready;
    assign stg_move = r_stg_vld && out_free;
    assign stg_room = !r_stg_vld || out_free;
    assign in_ready = (r_state == S_IDLE) && stg_room;
    assign in_fire  = i_cmd.valid && in_ready;
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == FullCount);

    assign i_cmd.ready  = in_ready;
    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_out_status;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.last   = r_out_last;

    // Command decode, pointer update and memory access selection.
    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_lidx    = r_lidx;
        wr_en     = 1'b0;
        wr_addr   = '0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        ld_stg    = 1'b0;
        ld_status = deq_pkg::ST_OK;
        ld_last   = 1'b1;
        ld_mem    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_cmd.opcode) inside
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                            ld_stg = 1'b1;
                            if (is_full) begin
                                ld_status = deq_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_cmd.opcode == deq_pkg::OP_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ? LastAddr : r_front - AW'(1);
                                    wr_addr = n_front;
                                end else begin
                                    wr_addr = ring_add(r_front, r_count);
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                            ld_stg = 1'b1;
                            if (is_empty) begin
                                ld_status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                ld_mem  = 1'b1;
                                n_count = r_count - CW'(1);
                                if (i_cmd.opcode == deq_pkg::OP_POP_FRONT) begin
                                    rd_addr = r_front;
                                    n_front = ring_add(r_front, CW'(1));
                                end else begin
                                    rd_addr = ring_add(r_front, r_count - CW'(1));
                                end
                            end
                        end
                        deq_pkg::OP_LIST: begin
                            if (is_empty) begin
                                ld_stg    = 1'b1;
                                ld_status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_LIST;
                                n_lidx  = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIST: begin
                // One held entry is read per cycle while the result stage has room.
                if (stg_room) begin
                    ld_stg  = 1'b1;
                    ld_mem  = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = ring_add(r_front, r_lidx);
                    ld_last = (r_lidx == r_count - CW'(1));
                    n_lidx  = r_lidx + CW'(1);
                    if (ld_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_lidx  <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_lidx  <= n_lidx;
        end
    end

    // Ring memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Result stage, valid in step with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else if (ld_stg) begin
            r_stg_vld <= 1'b1;
        end else if (stg_move) begin
            r_stg_vld <= 1'b0;
        end
        if (ld_stg) begin
            r_stg_status <= ld_status;
            r_stg_last   <= ld_last;
            r_stg_mem    <= ld_mem;
        end
    end

    // Output register, holding a result transaction until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (stg_move) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (stg_move) begin
            r_out_status <= r_stg_status;
            r_out_data   <= r_stg_mem ? r_rd_data : '0;
            r_out_last   <= r_stg_last;
        end
    end

    // The element count never passes the ring depth.
    `DEQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FullCount)
    // A read is only issued when the stage can take its result.
    `DEQ_ASSERT_NOW(a_read_room, i_clk, i_rst_n, rd_en, stg_room)
    // No command is accepted while a list streams.
    `DEQ_ASSERT_NOW(a_list_block, i_clk, i_rst_n, r_state == S_LIST, !in_ready)
    // The count moves by at most one per cycle.
    `DEQ_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1))
        || (r_count == $past(r_count) - CW'(1)))
    // A stalled result stage keeps its transaction.
    `DEQ_ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_stg_vld && !out_free, r_stg_vld)

endmodule

`default_nettype wire
